FILE: rtl/urx_pkg.sv
// Shared types, constants and control program for the serial receive ring.
// Depends on nothing; used by rtl/uart_rx_ring_with_resync_core.sv.
package urx_pkg;

    localparam int RING_DEPTH_DEF = 128;
    localparam int CFG_IDX_W      = 4;
    localparam int AVAIL_W        = 7;
    localparam int STEP_W         = 4;
    localparam int NUM_STEPS      = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_MARKER     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_ERR = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_REALIGN    = CFG_IDX_W'(3);

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_READ    = 1'b1;
    localparam logic KIND_MSG    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] SUB_FULL    = 8'd0;
    localparam logic [7:0] SUB_OVERRUN = 8'd1;
    localparam logic [1:0] MARKER_RUN_DONE = 2'd3;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_WAIT     = STEP_W'(0);
    localparam step_t ST_LAST_MSG = STEP_W'(9);
    localparam step_t ST_NWRITE   = STEP_W'(10);
    localparam step_t ST_RWRITE   = STEP_W'(11);
    localparam step_t ST_READ     = STEP_W'(12);
    localparam step_t ST_STATUS   = STEP_W'(13);

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic       rx_overrun;
    } req_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx_byte;
        logic [7:0]         read_data;
        logic               read_valid;
        logic [AVAIL_W-1:0] available;
        logic               realigning;
        logic               last;
    } rsp_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_ERR,
        SEL_SERR,
        SEL_SUB,
        SEL_RLN,
        SEL_ZERO,
        SEL_STATUS
    } sel_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_ENTER_RLN,
        ACT_WR_ADV,
        ACT_RLN_WR,
        ACT_RD_POP
    } act_t;

    typedef enum logic [2:0] {
        CND_NEXT,
        CND_ALWAYS,
        CND_NO_ITEM,
        CND_IS_READ,
        CND_REALIGN,
        CND_NO_ERROR
    } cnd_t;

    typedef struct packed {
        sel_t  sel;
        act_t  act;
        cnd_t  cnd;
        step_t target;
    } ucode_t;

    localparam ucode_t UCODE [NUM_STEPS] = '{
        '{SEL_NONE,   ACT_LATCH,     CND_NO_ITEM,  ST_WAIT},
        '{SEL_NONE,   ACT_NONE,      CND_IS_READ,  ST_READ},
        '{SEL_NONE,   ACT_NONE,      CND_REALIGN,  ST_RWRITE},
        '{SEL_NONE,   ACT_NONE,      CND_NO_ERROR, ST_NWRITE},
        '{SEL_ERR,    ACT_NONE,      CND_NEXT,     ST_WAIT},
        '{SEL_SERR,   ACT_NONE,      CND_NEXT,     ST_WAIT},
        '{SEL_SUB,    ACT_NONE,      CND_NEXT,     ST_WAIT},
        '{SEL_RLN,    ACT_NONE,      CND_NEXT,     ST_WAIT},
        '{SEL_ZERO,   ACT_NONE,      CND_NEXT,     ST_WAIT},
        '{SEL_ZERO,   ACT_ENTER_RLN, CND_NEXT,     ST_WAIT},
        '{SEL_NONE,   ACT_WR_ADV,    CND_ALWAYS,   ST_STATUS},
        '{SEL_NONE,   ACT_RLN_WR,    CND_ALWAYS,   ST_STATUS},
        '{SEL_NONE,   ACT_RD_POP,    CND_NEXT,     ST_WAIT},
        '{SEL_STATUS, ACT_NONE,      CND_ALWAYS,   ST_WAIT}
    };

endpackage

FILE: rtl/uart_rx_ring_with_resync_core.sv
// Serial receive ring buffer with resync, run by a microcoded step sequencer.
// Depends on rtl/urx_pkg.sv (types, register indexes, control program).

// One item is handled at a time. A read pops the ring and returns a status
// result, a byte in normal mode is stored, and a byte in realign mode is
// checked against the marker run. A byte that meets a full ring or an overrun
// first raises the error and realign messages, enters realign mode and is then
// stored. Every item ends with a status result, and a stalled result holds the
// sequencer. The ring is a single-port-write, registered-
// read memory of RING_DEPTH bytes and needs no clearing after reset.
module uart_rx_ring_with_resync_core #(
    parameter int RING_DEPTH = urx_pkg::RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  urx_pkg::req_t                 req_item,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output urx_pkg::rsp_t                 rsp_item,
    input  logic                          cfg_we,
    input  logic [urx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_wdata
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(RING_DEPTH);

    logic [7:0] mem [RING_DEPTH];
    logic [7:0] rd_q;

    urx_pkg::step_t  step_reg, step_next;
    urx_pkg::ucode_t cw;
    urx_pkg::req_t   item_reg;
    urx_pkg::rsp_t   out_reg, out_next;

    logic             out_valid_reg, out_valid_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic             realign_reg, realign_next;
    logic [1:0]       run_reg, run_next;
    logic             rv_reg, rv_next;
    logic [7:0]       marker_reg, error_reg, serr_reg, rlncode_reg;

    logic             req_fire, slot_free, go, emit, jump;
    logic             full, empty, is_marker, mem_we, mem_re;
    logic [PTR_W-1:0] wptr_inc, rptr_inc, held;
    logic [PTR_W:0]   held_ext;
    logic [PTR_W+urx_pkg::AVAIL_W-1:0] held_wide;
    logic [1:0]       run_inc;

    assign cw        = urx_pkg::UCODE[step_reg];
    assign req_stall = (cw.act != urx_pkg::ACT_LATCH);
    assign req_fire  = req_valid && !req_stall;
    assign slot_free = !out_valid_reg || !rsp_stall;
    assign emit      = (cw.sel != urx_pkg::SEL_NONE);
    assign go        = !emit || slot_free;

    assign wptr_inc  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
    assign rptr_inc  = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
    assign full      = (wptr_inc == rptr_reg);
    assign empty     = (wptr_reg == rptr_reg);
    assign held_ext  = {1'b0, wptr_reg} + ((wptr_reg < rptr_reg) ? DEPTH_EXT : '0)
                       - {1'b0, rptr_reg};
    assign held      = held_ext[PTR_W-1:0];
    assign held_wide = {{urx_pkg::AVAIL_W{1'b0}}, held};
    assign is_marker = (item_reg.rx_byte == marker_reg);
    assign run_inc   = run_reg + 2'd1;

    assign mem_we = go && ((cw.act == urx_pkg::ACT_WR_ADV) || (cw.act == urx_pkg::ACT_RLN_WR));
    assign mem_re = go && (cw.act == urx_pkg::ACT_RD_POP) && !empty;

    always_comb
    begin
        unique case (cw.cnd)
            urx_pkg::CND_NEXT:     jump = 1'b0;
            urx_pkg::CND_ALWAYS:   jump = 1'b1;
            urx_pkg::CND_NO_ITEM:  jump = !req_fire;
            urx_pkg::CND_IS_READ:  jump = (item_reg.req_type == urx_pkg::REQ_READ);
            urx_pkg::CND_REALIGN:  jump = realign_reg;
            urx_pkg::CND_NO_ERROR: jump = !(full || item_reg.rx_overrun);
            default:               jump = 1'b0;
        endcase
        if (!go)
            step_next = step_reg;
        else if (jump)
            step_next = cw.target;
        else
            step_next = step_reg + 1'b1;
    end

    always_comb
    begin
        out_next = '0;
        out_next.kind = urx_pkg::KIND_MSG;
        unique case (cw.sel)
            urx_pkg::SEL_ERR:  out_next.tx_byte = error_reg;
            urx_pkg::SEL_SERR: out_next.tx_byte = serr_reg;
            urx_pkg::SEL_SUB:  out_next.tx_byte = full ? urx_pkg::SUB_FULL
                                                       : urx_pkg::SUB_OVERRUN;
            urx_pkg::SEL_RLN:  out_next.tx_byte = rlncode_reg;
            urx_pkg::SEL_STATUS:
            begin
                out_next.kind       = urx_pkg::KIND_STATUS;
                out_next.read_data  = rv_reg ? rd_q : 8'd0;
                out_next.read_valid = rv_reg;
                out_next.available  = held_wide[urx_pkg::AVAIL_W-1:0];
                out_next.realigning = realign_reg;
                out_next.last       = 1'b1;
            end
            default:           out_next.tx_byte = 8'd0;
        endcase

        out_valid_next = out_valid_reg && rsp_stall;
        if (go && emit)
            out_valid_next = 1'b1;

        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        realign_next = realign_reg;
        run_next     = run_reg;
        rv_next      = rv_reg;
        if (go)
        begin
            unique case (cw.act)
                urx_pkg::ACT_LATCH:
                begin
                    if (req_fire)
                        rv_next = 1'b0;
                end
                urx_pkg::ACT_ENTER_RLN:
                begin
                    realign_next = 1'b1;
                    run_next     = 2'd0;
                end
                urx_pkg::ACT_WR_ADV:
                begin
                    wptr_next = wptr_inc;
                end
                urx_pkg::ACT_RLN_WR:
                begin
                    if (is_marker)
                    begin
                        run_next = run_inc;
                        if (run_inc == urx_pkg::MARKER_RUN_DONE)
                        begin
                            realign_next = 1'b0;
                            rptr_next    = wptr_reg;
                        end
                    end
                    else
                    begin
                        run_next  = 2'd0;
                        wptr_next = wptr_inc;
                    end
                end
                urx_pkg::ACT_RD_POP:
                begin
                    rv_next = !empty;
                    if (!empty)
                        rptr_next = rptr_inc;
                end
                default:
                begin
                    rv_next = rv_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= urx_pkg::ST_WAIT;
            out_valid_reg <= 1'b0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            realign_reg   <= 1'b0;
            run_reg       <= 2'd0;
            rv_reg        <= 1'b0;
            marker_reg    <= 8'd0;
            error_reg     <= 8'd0;
            serr_reg      <= 8'd0;
            rlncode_reg   <= 8'd0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            realign_reg   <= realign_next;
            run_reg       <= run_next;
            rv_reg        <= rv_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    urx_pkg::CFG_MARKER:     marker_reg  <= cfg_wdata;
                    urx_pkg::CFG_ERROR:      error_reg   <= cfg_wdata;
                    urx_pkg::CFG_SERIAL_ERR: serr_reg    <= cfg_wdata;
                    urx_pkg::CFG_REALIGN:    rlncode_reg <= cfg_wdata;
                    default:                 marker_reg  <= marker_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            item_reg <= req_item;
        if (go && emit)
            out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wptr_reg] <= item_reg.rx_byte;
        if (mem_re)
            rd_q <= mem[rptr_reg];
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

`ifndef NO_ASSERTIONS
    a_msg_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.kind == urx_pkg::KIND_MSG) |->
            !rsp_item.read_valid && !rsp_item.last && (rsp_item.available == '0))
        else $error("message item carries status fields");

    a_realign_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(realign_reg) |-> $past(step_reg) == urx_pkg::ST_LAST_MSG)
        else $error("realign mode entered outside the message sequence");

    a_wptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (wptr_reg != $past(wptr_reg)) |->
            ($past(step_reg) == urx_pkg::ST_NWRITE) || ($past(step_reg) == urx_pkg::ST_RWRITE))
        else $error("write pointer moved outside a write step");

    a_rptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (rptr_reg != $past(rptr_reg)) |->
            ($past(step_reg) == urx_pkg::ST_READ) || ($past(step_reg) == urx_pkg::ST_RWRITE))
        else $error("read pointer moved outside a read or resync step");
`endif

endmodule
